### design/drtb_pkg.sv
// Shared types and constants for the display row table builder.
package drtb_pkg;

	// Width of the unreduced address sums (start*2 + 4*row stays below 2**18).
	localparam int REDUCE_W = 18;
	// Width of the shift amount used by the address reduction steps.
	localparam int SHIFT_W = 3;
	// Width of the entry index field.
	localparam int IDX_W = 6;
	// Mask applied to the descriptor high byte before forming the pointer.
	localparam logic [7:0] HI_MASK = 8'h3f;

	typedef enum logic [0:0] {
		OP_WRITE = 1'b0,
		OP_BUILD = 1'b1
	} op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic               cap;
		logic               red_step;
		logic [SHIFT_W-1:0] shamt;
		logic               ram_wr;
		logic               rd_desc;
		logic               rd_word;
		logic [IDX_W-1:0]   idx;
		logic               last;
	} drtb_cmd_t;

endpackage

### design/drtb_ctrl.sv
// Controller state machine that sequences writes and row builds.
module drtb_ctrl
	import drtb_pkg::*;
#(
	parameter int ROWS            = 37,
	parameter int ENTRIES_PER_ROW = 63,
	parameter int RAM_BYTES       = 65536
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             opcode,
	input  logic [5:0]       row_number,
	output logic             busy,
	output drtb_cmd_t        cmd
);

	localparam int AW        = $clog2(RAM_BYTES);
	localparam int RED_STEPS = REDUCE_W - AW + 1;
	localparam int MAX_IDX   = (1 << IDX_W) - 1;
	localparam int LAST_IDX  = (ENTRIES_PER_ROW > MAX_IDX) ? MAX_IDX : ENTRIES_PER_ROW;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RED_WR,
		S_WRITE,
		S_RED_DESC,
		S_RD_DESC,
		S_DESC_WAIT,
		S_RED_PTR,
		S_RD_WORDS
	} state_t;

	state_t             state_q;
	logic [SHIFT_W-1:0] step_q;
	logic [IDX_W-1:0]   idx_q;
	logic               row_ok;
	logic               last_word;

	assign row_ok    = ({1'b0, row_number} < 7'(ROWS));
	assign last_word = (idx_q == IDX_W'(LAST_IDX));
	assign busy      = (state_q != S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.cap      = (state_q == S_IDLE) && start;
		cmd.shamt    = step_q;
		cmd.idx      = idx_q;
		cmd.last     = last_word;
		case (state_q)
			S_RED_WR, S_RED_DESC, S_RED_PTR: begin
				cmd.red_step = 1'b1;
			end
			S_WRITE: begin
				cmd.ram_wr = 1'b1;
			end
			S_RD_DESC: begin
				cmd.rd_desc = 1'b1;
			end
			S_RD_WORDS: begin
				cmd.rd_word = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					step_q <= SHIFT_W'(RED_STEPS - 1);
					if (start) begin
						if (op_t'(opcode) == OP_WRITE) begin
							state_q <= S_RED_WR;
						end else if (row_ok) begin
							state_q <= S_RED_DESC;
						end
					end
				end
				S_RED_WR: begin
					step_q <= step_q - SHIFT_W'(1);
					if (step_q == '0) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					state_q <= S_IDLE;
				end
				S_RED_DESC: begin
					step_q <= step_q - SHIFT_W'(1);
					if (step_q == '0) begin
						state_q <= S_RD_DESC;
					end
				end
				S_RD_DESC: begin
					state_q <= S_DESC_WAIT;
				end
				S_DESC_WAIT: begin
					// The datapath reloads the reducer with the pointer base here.
					step_q  <= SHIFT_W'(RED_STEPS - 1);
					idx_q   <= IDX_W'(1);
					state_q <= S_RED_PTR;
				end
				S_RED_PTR: begin
					step_q <= step_q - SHIFT_W'(1);
					if (step_q == '0) begin
						state_q <= S_RD_WORDS;
					end
				end
				S_RD_WORDS: begin
					idx_q <= idx_q + IDX_W'(1);
					if (last_word) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_word_idx_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_word |-> (cmd.idx != '0))
		else $error("word read issued with entry index zero");

	a_last_word_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_word && cmd.last) |=> (state_q == S_IDLE))
		else $error("controller did not return to idle after the last word");

	a_write_after_reduce: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ram_wr |-> ($past(state_q) == S_RED_WR))
		else $error("RAM write without a finished address reduction");
`endif

endmodule

### design/drtb_dp.sv
// Datapath: display RAM, address reduction and result registers.
module drtb_dp
	import drtb_pkg::*;
#(
	parameter int RAM_BYTES = 65536
) (
	input  logic             clk,
	input  logic             arst_n,
	input  drtb_cmd_t        cmd,
	input  logic             cfg_valid,
	input  logic [15:0]      cfg_data,
	input  logic             opcode,
	input  logic [15:0]      ram_address,
	input  logic [7:0]       write_byte,
	input  logic [5:0]       row_number,
	output logic             result_valid,
	output logic [15:0]      entry_word,
	output logic [IDX_W-1:0] entry_index,
	output logic             last_entry
);

	localparam int AW = $clog2(RAM_BYTES);
	localparam logic [AW:0]       R_A = (AW + 1)'(RAM_BYTES);
	localparam logic [REDUCE_W:0] R_V = (REDUCE_W + 1)'(RAM_BYTES);

	// Adds a small offset to an address that is already below RAM_BYTES.
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [1:0] c);
		logic [AW:0] s;
		s = {1'b0, a} + (AW + 1)'(c);
		if (s >= R_A) begin
			s = s - R_A;
		end
		return s[AW-1:0];
	endfunction

	logic [15:0]         cfg_start_q;
	logic [7:0]          wbyte_q;
	logic [REDUCE_W-1:0] red_val_q;
	logic [7:0]          mem [RAM_BYTES];
	logic [7:0]          rd0_q;
	logic [7:0]          rd1_q;
	logic                desc_vld_s1;
	logic                word_vld_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic                last_s1;
	logic                result_valid_q;
	logic [15:0]         entry_word_q;
	logic [IDX_W-1:0]    entry_index_q;
	logic                last_entry_q;

	logic [REDUCE_W-1:0] desc_sum;
	logic [REDUCE_W-1:0] ptr_base;
	logic [REDUCE_W:0]   red_sub;
	logic [AW-1:0]       cur_addr;
	logic [AW-1:0]       ra0;
	logic [AW-1:0]       ra1;
	logic [7:0]          hi_masked;

	assign desc_sum  = REDUCE_W'({cfg_start_q, 1'b0}) + REDUCE_W'({row_number, 2'b00});
	assign hi_masked = rd1_q & HI_MASK;
	assign ptr_base  = REDUCE_W'({hi_masked, rd0_q, 1'b0});
	assign red_sub   = R_V << cmd.shamt;
	assign cur_addr  = red_val_q[AW-1:0];

	// The descriptor bytes sit at offsets one and three; words at p and p+1.
	assign ra0 = cmd.rd_desc ? wrap_add(cur_addr, 2'd1) : cur_addr;
	assign ra1 = cmd.rd_desc ? wrap_add(cur_addr, 2'd3) : wrap_add(cur_addr, 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_start_q <= '0;
		end else if (cfg_valid) begin
			cfg_start_q <= cfg_data;
		end
	end

	// Shared address register: it is reduced modulo RAM_BYTES by restoring
	// subtract steps and then walks the pointer during the word reads.
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			wbyte_q <= write_byte;
			if (op_t'(opcode) == OP_BUILD) begin
				red_val_q <= desc_sum;
			end else begin
				red_val_q <= REDUCE_W'(ram_address);
			end
		end else if (desc_vld_s1) begin
			red_val_q <= ptr_base;
		end else if (cmd.red_step) begin
			if ({1'b0, red_val_q} >= red_sub) begin
				red_val_q <= REDUCE_W'({1'b0, red_val_q} - red_sub);
			end
		end else if (cmd.rd_word) begin
			red_val_q <= REDUCE_W'(wrap_add(cur_addr, 2'd2));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ram_wr) begin
			mem[cur_addr] <= wbyte_q;
		end
		rd0_q <= mem[ra0];
		rd1_q <= mem[ra1];
	end

	always_ff @(posedge clk) begin
		idx_s1  <= cmd.idx;
		last_s1 <= cmd.last;
		if (desc_vld_s1) begin
			entry_word_q  <= {rd1_q, rd0_q};
			entry_index_q <= '0;
			last_entry_q  <= 1'b0;
		end else if (word_vld_s1) begin
			entry_word_q  <= {rd0_q, rd1_q};
			entry_index_q <= idx_s1;
			last_entry_q  <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_vld_s1    <= 1'b0;
			word_vld_s1    <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			desc_vld_s1    <= cmd.rd_desc;
			word_vld_s1    <= cmd.rd_word;
			result_valid_q <= desc_vld_s1 || word_vld_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign entry_word   = entry_word_q;
	assign entry_index  = entry_index_q;
	assign last_entry   = last_entry_q;

`ifndef SYNTH
	a_words_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && (entry_index_q != '0) && !last_entry_q) |=>
		(result_valid_q && (entry_index_q == $past(entry_index_q) + IDX_W'(1))))
		else $error("entry words of a row are not consecutive");

	a_desc_result: assert property (@(posedge clk) disable iff (!arst_n)
		desc_vld_s1 |=> (result_valid_q && (entry_index_q == '0)))
		else $error("descriptor read did not produce entry zero");
`endif

endmodule

### design/display_row_table_builder.sv
// Top level of the display row table builder.
// A request is taken when start is high and busy is low. A write request
// stores write_byte at ram_address (modulo RAM_BYTES) with no result; the
// next request can be taken once the address is reduced and the byte is
// written. A build request for a row below ROWS reads the row descriptor
// and then min(ENTRIES_PER_ROW,63) entry words, one 16-bit word per cycle
// from a two-read-port RAM, and is ready for the next request once the last
// word is read. There are 19-clog2(RAM_BYTES) address reduction steps, one
// per cycle, done once for the descriptor address and once for the pointer.
// A build of a row at or above ROWS produces nothing. Each result is shown
// for exactly one cycle with result_valid high; the receiver cannot stall,
// and the last word of a row appears in the cycle after busy falls. The
// display start register is written through cfg_valid/cfg_data, always
// ready. The user must write it only while idle; it is not enforced.
module display_row_table_builder
	import drtb_pkg::*;
#(
	parameter int ROWS            = 37,
	parameter int ENTRIES_PER_ROW = 63,
	parameter int RAM_BYTES       = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        opcode,
	input  logic [15:0] ram_address,
	input  logic [7:0]  write_byte,
	input  logic [5:0]  row_number,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output logic        result_valid,
	output logic [15:0] entry_word,
	output logic [5:0]  entry_index,
	output logic        last_entry
);

	drtb_cmd_t cmd;

	assign cfg_ready = 1'b1;

	drtb_ctrl #(
		.ROWS            (ROWS),
		.ENTRIES_PER_ROW (ENTRIES_PER_ROW),
		.RAM_BYTES       (RAM_BYTES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.opcode     (opcode),
		.row_number (row_number),
		.busy       (busy),
		.cmd        (cmd)
	);

	drtb_dp #(
		.RAM_BYTES (RAM_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.opcode       (opcode),
		.ram_address  (ram_address),
		.write_byte   (write_byte),
		.row_number   (row_number),
		.result_valid (result_valid),
		.entry_word   (entry_word),
		.entry_index  (entry_index),
		.last_entry   (last_entry)
	);

endmodule

### tb/sv/row_table_checker.sv
// Channel monitor and entry checker for the display row table builder.
module row_table_checker
	import drtb_pkg::*;
#(
	parameter int ROWS            = 37,
	parameter int ENTRIES_PER_ROW = 63,
	parameter int RAM_BYTES       = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        opcode,
	input  logic [15:0] ram_address,
	input  logic [7:0]  write_byte,
	input  logic [5:0]  row_number,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        result_valid,
	input  logic [15:0] entry_word,
	input  logic [5:0]  entry_index,
	input  logic        last_entry,
	output int          failures,
	output int          pending,
	output int          checked
);

	localparam int MAX_ENTRIES = 64;
	localparam int ROW_ENTRIES = (ENTRIES_PER_ROW + 1 > MAX_ENTRIES) ? MAX_ENTRIES
		: ENTRIES_PER_ROW + 1;

	typedef struct packed {
		logic [15:0]      word;
		logic [IDX_W-1:0] index;
		logic             last;
	} table_entry_t;

	logic [7:0]   ram_copy [RAM_BYTES];
	logic [15:0]  start_word;
	table_entry_t expected_entries [$];

	function automatic logic [7:0] ram_byte(input int unsigned addr);
		return ram_copy[addr % RAM_BYTES];
	endfunction

	// The descriptor comes first, then the words that its masked pointer selects.
	function automatic void predict_row(input logic [5:0] row);
		int unsigned  desc_addr;
		int unsigned  ptr;
		logic [7:0]   lo;
		logic [7:0]   hi;
		table_entry_t ent;
		desc_addr = start_word * 2 + 4 * row;
		lo = ram_byte(desc_addr + 1);
		hi = ram_byte(desc_addr + 3);
		ent.word  = {hi, lo};
		ent.index = '0;
		ent.last  = (ROW_ENTRIES == 1);
		expected_entries.push_back(ent);
		ptr = {hi & HI_MASK, lo} * 2;
		for (int k = 1; k < ROW_ENTRIES; k++) begin
			ent.word  = {ram_byte(ptr), ram_byte(ptr + 1)};
			ent.index = k[IDX_W-1:0];
			ent.last  = (k == ROW_ENTRIES - 1);
			expected_entries.push_back(ent);
			ptr += 2;
		end
	endfunction

	function automatic void report_field(input string field, input int exp_val,
			input int act_val);
		failures++;
		$display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_val,
			act_val);
	endfunction

	function automatic void check_entry();
		table_entry_t exp_ent;
		if (expected_entries.size() == 0) begin
			failures++;
			$display("%0t: entry with nothing expected, expected none, got word %h index %0d",
				$time, entry_word, entry_index);
			return;
		end
		exp_ent = expected_entries.pop_front();
		checked++;
		if (entry_word !== exp_ent.word)
			report_field("entry_word", exp_ent.word, entry_word);
		if (entry_index !== exp_ent.index)
			report_field("entry_index", exp_ent.index, entry_index);
		if (last_entry !== exp_ent.last)
			report_field("last_entry", exp_ent.last, last_entry);
	endfunction

	initial begin
		failures = 0;
		checked  = 0;
		pending  = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_word = '0;
			expected_entries.delete();
			pending = 0;
		end else begin
			if (result_valid)
				check_entry();
			// A request taken at this edge still sees the old display start.
			if (start && !busy) begin
				if (op_t'(opcode) == OP_WRITE)
					ram_copy[ram_address % RAM_BYTES] = write_byte;
				else if (row_number < ROWS)
					predict_row(row_number);
			end
			if (cfg_valid && cfg_ready)
				start_word = cfg_data;
			pending = expected_entries.size();
		end
	end

endmodule

### tb/sv/testbench.sv
// Top of the display row table builder testbench: stimulus and verdict.
module testbench;
	import drtb_pkg::*;

	localparam int CLK_PERIOD      = 20;
	localparam int ROWS            = 37;
	localparam int ENTRIES_PER_ROW = 63;
	localparam int RAM_BYTES       = 65536;
	localparam int WINDOW_BYTES    = 2 * ENTRIES_PER_ROW;
	localparam int PTR_WORDS       = 16384;
	localparam int SETTLE_CYCLES   = 12;
	localparam int PHASE_ITEMS     = 20;
	localparam int LIMIT_CYCLES    = 400000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        opcode;
	logic [15:0] ram_address;
	logic [7:0]  write_byte;
	logic [5:0]  row_number;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;
	logic        result_valid;
	logic [15:0] entry_word;
	logic [5:0]  entry_index;
	logic        last_entry;
	int          failures;
	int          pending;
	int          checked;

	bit          written [RAM_BYTES];
	logic [15:0] start_cfg;
	int unsigned used_ptrs [$];
	int          n_writes;
	int          n_builds;
	int          n_ignored;
	int          n_settings;
	bit          steady;

	always #(CLK_PERIOD / 2) clk = ~clk;

	display_row_table_builder #(
		.ROWS           (ROWS),
		.ENTRIES_PER_ROW(ENTRIES_PER_ROW),
		.RAM_BYTES      (RAM_BYTES)
	) DUT (.*);

	row_table_checker #(
		.ROWS           (ROWS),
		.ENTRIES_PER_ROW(ENTRIES_PER_ROW),
		.RAM_BYTES      (RAM_BYTES)
	) row_check (.*);

	task automatic idle_gap();
		int gap;
		if (!steady && $urandom_range(0, 99) < 12) begin
			// Mostly short gaps, sometimes long enough to land past the end of a build.
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 4);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_item(input op_t op, input logic [15:0] addr, input logic [7:0] data,
			input logic [5:0] row);
		idle_gap();
		opcode      <= op;
		ram_address <= addr;
		write_byte  <= data;
		row_number  <= row;
		start       <= 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
		if (op == OP_WRITE) begin
			written[addr] = 1'b1;
			n_writes++;
		end else if (row < ROWS) begin
			n_builds++;
		end else begin
			n_ignored++;
		end
	endtask

	task automatic write_rand(input logic [15:0] addr);
		send_item(OP_WRITE, addr, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending != 0 || busy) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_display_start(input logic [15:0] value);
		drain();
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		start_cfg = value;
		n_settings++;
	endtask

	// Every byte the build will read is written before the build request goes out.
	// Window bytes are touched before the descriptor so they cannot move the pointer.
	task automatic build_row(input logic [5:0] row, input logic [13:0] ptr_word,
			input logic [1:0] hi_top);
		logic [15:0] desc_addr;
		logic [15:0] addr;
		for (int i = 0; i < WINDOW_BYTES; i++) begin
			addr = 16'(ptr_word * 2 + i);
			if (!written[addr])
				write_rand(addr);
		end
		repeat ($urandom_range(0, 3))
			write_rand(16'(ptr_word * 2 + $urandom_range(0, WINDOW_BYTES - 1)));
		desc_addr = 16'(start_cfg * 2 + 4 * row);
		send_item(OP_WRITE, desc_addr + 16'd1, ptr_word[7:0], 6'($urandom_range(0, 63)));
		send_item(OP_WRITE, desc_addr + 16'd3, {hi_top, ptr_word[13:8]},
			6'($urandom_range(0, 63)));
		send_item(OP_BUILD, 16'($urandom), 8'($urandom), row);
	endtask

	task automatic random_phase();
		int          goal;
		int          roll;
		int unsigned ptr_word;
		logic [5:0]  row;
		goal = n_writes + n_builds + PHASE_ITEMS;
		while (n_writes + n_builds < goal) begin
			roll = $urandom_range(0, 99);
			if (roll < 15) begin
				write_rand(16'($urandom_range(0, RAM_BYTES - 1)));
			end else if (roll < 20) begin
				send_item(OP_BUILD, 16'($urandom), 8'($urandom), 6'($urandom_range(ROWS, 63)));
			end else begin
				// Reuse nearby windows most of the time so a build needs few fill writes.
				if (used_ptrs.size() == 0 || $urandom_range(0, 99) < 5)
					ptr_word = $urandom_range(0, PTR_WORDS - 1);
				else
					ptr_word = (used_ptrs[$urandom_range(0, used_ptrs.size() - 1)]
						+ $urandom_range(0, 2)) % PTR_WORDS;
				used_ptrs.push_back(ptr_word);
				row = 6'($urandom_range(0, ROWS - 1));
				build_row(row, 14'(ptr_word), 2'($urandom_range(0, 3)));
				if ($urandom_range(0, 99) < 5)
					send_item(OP_BUILD, 16'($urandom), 8'($urandom), row);
			end
		end
	endtask

	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		opcode      = 1'b0;
		ram_address = '0;
		write_byte  = '0;
		row_number  = '0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		start_cfg   = '0;
		steady      = 1'b0;
		n_writes    = 0;
		n_builds    = 0;
		n_ignored   = 0;
		n_settings  = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: pointer extremes, masked high bits, wrapping descriptor,
		// address and data extremes, and rows past the end of the table.
		set_display_start(16'h0000);
		build_row(6'd0, 14'd0, 2'b11);
		build_row(6'd36, 14'h3fff, 2'b11);
		used_ptrs.push_back(0);
		used_ptrs.push_back(14'h3fff);
		send_item(OP_WRITE, 16'hffff, 8'hff, 6'h3f);
		send_item(OP_WRITE, 16'h0000, 8'h00, 6'h00);
		send_item(OP_BUILD, 16'hffff, 8'hff, 6'd37);
		send_item(OP_BUILD, 16'h0000, 8'h00, 6'd63);
		set_display_start(16'hffff);
		build_row(6'd36, 14'h3fff, 2'b00);
		build_row(6'd0, 14'd0, 2'b01);

		random_phase();
		steady = 1'b1;
		set_display_start(16'($urandom));
		random_phase();
		steady = 1'b0;
		set_display_start(16'h0000);
		random_phase();
		set_display_start(16'($urandom));
		random_phase();
		drain();

		$display("Ran %0d byte writes and %0d row builds (%0d out-of-range rows) under %0d display start values.",
			n_writes, n_builds, n_ignored, n_settings);
		$display("Compared %0d table entries with the prediction.", checked);
		if (failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
